>>> hdl/i2cscp_pkg.sv
// Package for the I2C slave command port: status codes, register indexes,
// configuration and result structures. No dependencies.
package i2cscp_pkg;

    localparam logic [7:0] ST_MASK    = 8'hF8;
    localparam logic [7:0] ST_RX_DATA = 8'h80;
    localparam logic [7:0] ST_STOP    = 8'hA0;
    localparam logic [7:0] ST_RD_ADDR = 8'hA8;
    localparam logic [7:0] ST_RD_ARB  = 8'hB0;
    localparam logic [7:0] ST_RD_BYTE = 8'hB8;

    localparam logic [7:0] FREQ_LIMIT   = 8'd20;
    localparam logic [6:0] FREQ_LOW_MUL = 7'd50;
    localparam logic [6:0] FREQ_HI_MUL  = 7'd100;

    localparam logic [3:0] READ_MAX  = 4'd8;
    localparam logic [3:0] READ_MIN  = 4'd1;
    localparam logic [3:0] READ_NONE = 4'd0;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COUNT = 2'd2;

    typedef struct packed {
        logic [7:0]  freq_code;
        logic [63:0] read_bytes;
        logic [3:0]  read_count;
    } cfg_t;

    typedef struct packed {
        logic        ack;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        command_done;
        logic [7:0]  command_out;
        logic [4:0]  param_total;
        logic        freq_valid;
        logic [14:0] freq_value;
    } result_t;

endpackage

>>> hdl/i2cscp_cfg_regs.sv
// Configuration registers of the I2C slave command port.
// Depends on i2cscp_pkg for register indexes and the cfg_t structure.
module i2cscp_cfg_regs
    import i2cscp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FREQ_CODE:  cfg_next.freq_code  = cfg_data[7:0];
                CFG_READ_BYTES: cfg_next.read_bytes = cfg_data;
                CFG_READ_COUNT: cfg_next.read_count = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_code  <= 8'd0;
            cfg_reg.read_bytes <= 64'd0;
            cfg_reg.read_count <= READ_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/i2cscp_event_unit.sv
// Per-event logic of the I2C slave command port: write and read state and the
// result of one bus event. Depends on i2cscp_pkg.
module i2cscp_event_unit
    import i2cscp_pkg::*;
#(
    parameter int PARAM_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] status,
    input  logic [7:0] rx,
    input  cfg_t       cfg,
    output result_t    res
);

    localparam int CNT_W = $clog2(PARAM_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PARAM_DEPTH);

    // Only the first parameter byte is ever used, so only it is stored.
    logic             in_write_reg, in_write_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       param0_reg, param0_next;
    logic [CNT_W-1:0] param_count_reg, param_count_next;
    logic [2:0]       read_index_reg, read_index_next;

    logic [7:0]       masked;
    logic [3:0]       eff_count;
    logic [2:0]       byte_index;
    logic [3:0]       index_plus;
    logic [6:0]       freq_mul;
    logic [14:0]      freq_product;
    logic [CNT_W+4:0] count_wide;

    assign masked = status & ST_MASK;

    always_comb
    begin
        if (cfg.read_count == READ_NONE)
        begin
            eff_count = READ_MIN;
        end
        else if (cfg.read_count > READ_MAX)
        begin
            eff_count = READ_MAX;
        end
        else
        begin
            eff_count = cfg.read_count;
        end
    end

    assign byte_index   = (masked == ST_RD_BYTE) ? read_index_reg : 3'd0;
    assign index_plus   = {1'b0, byte_index} + 4'd1;
    assign freq_mul     = (param0_reg <= FREQ_LIMIT) ? FREQ_LOW_MUL : FREQ_HI_MUL;
    assign freq_product = 15'({7'd0, param0_reg} * {8'd0, freq_mul});
    assign count_wide   = {5'd0, param_count_reg};

    always_comb
    begin
        in_write_next    = in_write_reg;
        command_next     = command_reg;
        param0_next      = param0_reg;
        param_count_next = param_count_reg;
        read_index_next  = read_index_reg;
        res              = '0;
        res.ack          = 1'b1;

        case (masked)
            ST_RX_DATA:
            begin
                if (!in_write_reg)
                begin
                    command_next  = rx;
                    in_write_next = 1'b1;
                end
                else if (param_count_reg < CNT_MAX)
                begin
                    if (param_count_reg == '0)
                    begin
                        param0_next = rx;
                    end
                    param_count_next = param_count_reg + 1'b1;
                end
            end
            ST_STOP:
            begin
                if (in_write_reg)
                begin
                    res.command_done = 1'b1;
                    res.command_out  = command_reg;
                    res.param_total  = count_wide[4:0];
                    if (command_reg == cfg.freq_code)
                    begin
                        res.freq_valid = 1'b1;
                        res.freq_value = freq_product;
                    end
                end
                in_write_next    = 1'b0;
                param_count_next = '0;
            end
            ST_RD_ADDR, ST_RD_ARB, ST_RD_BYTE:
            begin
                res.tx_valid = 1'b1;
                res.tx_byte  = cfg.read_bytes[{byte_index, 3'b000} +: 8];
                if (index_plus >= eff_count)
                begin
                    res.ack         = 1'b0;
                    read_index_next = 3'd0;
                end
                else
                begin
                    read_index_next = index_plus[2:0];
                end
            end
            default:
            begin
                res.ack = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_write_reg    <= 1'b0;
            command_reg     <= 8'd0;
            param0_reg      <= 8'd0;
            param_count_reg <= '0;
            read_index_reg  <= 3'd0;
        end
        else if (fire)
        begin
            in_write_reg    <= in_write_next;
            command_reg     <= command_next;
            param0_reg      <= param0_next;
            param_count_reg <= param_count_next;
            read_index_reg  <= read_index_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        param_count_reg <= CNT_MAX)
        else $error("parameter count above store depth");

    a_count_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        !in_write_reg |-> param_count_reg == '0)
        else $error("parameters counted outside a write");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && masked == ST_STOP |=> !in_write_reg && param_count_reg == '0)
        else $error("stop did not end the write");

endmodule

>>> hdl/i2c_slave_command_port.sv
// Top level of the I2C slave command port: input register, event unit and
// result register. Depends on i2cscp_pkg, i2cscp_cfg_regs, i2cscp_event_unit.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_stall   | bus_status, rx_byte
//  output   | out_valid / out_stall | ack, tx_valid, tx_byte, command_done,
//           |                       | command_out, param_total, freq_valid, freq_value
//  config   | cfg_write             | cfg_index, cfg_data
//
// One transaction can be accepted every cycle while in_stall is low; its result
// passes through the input register and then the result register to the output.
// Each event updates the command state in the same cycle that it leaves the
// input register. Reset clears the valid flags, the command state and the
// configuration and sets the read count to eight. A stalled output holds the
// result register, and the input register then holds as well, so in_stall rises once both registers are full.
module i2c_slave_command_port
    import i2cscp_pkg::*;
#(
    parameter int PARAM_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           bus_status,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ack,
    output logic                 tx_valid,
    output logic [7:0]           tx_byte,
    output logic                 command_done,
    output logic [7:0]           command_out,
    output logic [4:0]           param_total,
    output logic                 freq_valid,
    output logic [14:0]          freq_value,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic       in_valid_reg;
    logic [7:0] status_reg;
    logic [7:0] rx_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    cfg_t       cfg;
    logic       advance;
    logic       take_in;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            status_reg <= bus_status;
            rx_reg     <= rx_byte;
        end
    end

    i2cscp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cscp_event_unit #(
        .PARAM_DEPTH (PARAM_DEPTH)
    ) u_event_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (in_valid_reg && advance),
        .status (status_reg),
        .rx     (rx_reg),
        .cfg    (cfg),
        .res    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ack          = result_reg.ack;
    assign tx_valid     = result_reg.tx_valid;
    assign tx_byte      = result_reg.tx_byte;
    assign command_done = result_reg.command_done;
    assign command_out  = result_reg.command_out;
    assign param_total  = result_reg.param_total;
    assign freq_valid   = result_reg.freq_valid;
    assign freq_value   = result_reg.freq_value;

    a_nack_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ack || tx_valid)
        else $error("NACK without a byte to send");

    a_freq_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && freq_valid |-> command_done)
        else $error("frequency reported without a finished command");

    a_send_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tx_valid && command_done))
        else $error("send and command end in one transaction");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && in_valid_reg)
        else $error("input stalled while the result register is free");

endmodule
